>>> rtl/rqs_pkg.sv
`default_nettype none

package rqs_pkg;

    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 8;
    localparam int QSHIFT   = 16 - FRAC_W;
    localparam int BQ_W     = COEF_W + QSHIFT;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int DISC_W   = 35;
    localparam int RES_W    = 32;
    localparam int NUM_W    = 36;
    localparam int MAG_W    = 34;
    localparam int SQ_IN_W  = 50;
    localparam int SQ_STEPS = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_STEPS + 4;
    localparam int DIV_NW   = MAG_W + 16;
    localparam int DIV_DW   = COEF_W + 10;

    typedef enum logic [1:0] {
        CLS_TWO     = 2'd0,
        CLS_DOUBLE  = 2'd1,
        CLS_COMPLEX = 2'd2,
        CLS_DEGEN   = 2'd3
    } root_class_t;

    typedef struct packed {
        logic                     valid;
        logic signed [COEF_W-1:0] a;
        logic signed [BQ_W-1:0]   bq;
        logic signed [DISC_W-1:0] disc;
    } sq_side_t;

    typedef struct packed {
        logic                     valid;
        root_class_t              cls;
        logic signed [DISC_W-1:0] disc;
        logic                     neg_rp;
        logic                     neg_rm;
        logic                     neg_vx;
        logic                     neg_vy;
    } div_side_t;

    typedef struct packed {
        logic             ov;
        logic [RES_W-1:0] value;
    } sat_t;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [NUM_W-1:0] v);
        logic [NUM_W-1:0] t;
        t = v[NUM_W-1] ? (~v + NUM_W'(1)) : v;
        return t[MAG_W-1:0];
    endfunction

    // Clamp an unsigned quotient to int32 range and apply the sign.
    function automatic sat_t sat_q(input logic [DIV_NW-1:0] q, input logic neg);
        logic [DIV_NW-1:0] lim;
        logic [RES_W-1:0]  mag;
        sat_t              r;
        lim     = neg ? (DIV_NW'(1) << (RES_W - 1)) : ((DIV_NW'(1) << (RES_W - 1)) - DIV_NW'(1));
        r.ov    = (q > lim);
        mag     = r.ov ? lim[RES_W-1:0] : q[RES_W-1:0];
        r.value = neg ? (~mag + RES_W'(1)) : mag;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/quadratic_root_solver.sv
`default_nettype none

// Quadratic root solver: takes a, b, c of a*x^2 + b*x + c = 0 as signed Q8.8
// words and returns the root class, the discriminant b*b - 4ac as signed
// Q19.16, and both real roots and the parabola vertex as signed Q16.16. The
// square root rounds down, quotients truncate toward zero, and roots and
// vertex saturate to 32 bits with overflow_flag set. Complex roots read as
// zero; a zero 'a' gives class degenerate with every other field zero. The
// block is a fixed pipeline of 80 register stages: input capture, two
// multiply/subtract stages, a 25-stage square root (one root bit per stage),
// an operand stage, four 50-stage restoring dividers running side by side
// (one quotient bit per stage), and the output register. One word is taken
// every cycle while the pipe runs. The whole pipe holds only while an output
// word waits under out_stall, so in_stall is exactly that.
module quadratic_root_solver
    import rqs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [COEF_W-1:0] coef_a,
    input  wire logic signed [COEF_W-1:0] coef_b,
    input  wire logic signed [COEF_W-1:0] coef_c,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic             [1:0]        root_class,
    output logic signed      [DISC_W-1:0] disc_value,
    output logic signed      [RES_W-1:0]  root_plus,
    output logic signed      [RES_W-1:0]  root_minus,
    output logic signed      [RES_W-1:0]  vertex_x,
    output logic signed      [RES_W-1:0]  vertex_y,
    output logic                          overflow_flag
);

    logic en;

    // Advance the whole pipe unless the output word is held.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---------------- stage 1: capture ----------------
    logic                     s1_valid_reg;
    logic signed [COEF_W-1:0] s1_a_reg, s1_b_reg, s1_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg <= coef_a;
            s1_b_reg <= coef_b;
            s1_c_reg <= coef_c;
        end
    end

    // ---------------- stage 2: products ----------------
    logic                     s2_valid_reg;
    logic signed [COEF_W-1:0] s2_a_reg, s2_b_reg;
    logic signed [PROD_W-1:0] s2_bb_reg, s2_ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_a_reg  <= s1_a_reg;
            s2_b_reg  <= s1_b_reg;
            s2_bb_reg <= s1_b_reg * s1_b_reg;
            s2_ac_reg <= s1_a_reg * s1_c_reg;
        end
    end

    // ---------------- stage 3: discriminant, square root seed ----------------
    logic signed [DISC_W-1:0] disc_next;
    sq_side_t                 sq_seed;

    assign disc_next = $signed({{(DISC_W - PROD_W){s2_bb_reg[PROD_W-1]}}, s2_bb_reg})
                     - $signed({s2_ac_reg[PROD_W-1], s2_ac_reg, 2'b00});

    always_comb
    begin
        sq_seed.valid = s2_valid_reg;
        sq_seed.a     = s2_a_reg;
        sq_seed.bq    = $signed({s2_b_reg, {QSHIFT{1'b0}}});
        sq_seed.disc  = disc_next;
    end

    sq_side_t                sq_side_reg [0:SQ_STEPS];
    logic [SQ_IN_W-1:0]      sq_x_reg    [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]     sq_rem_reg  [0:SQ_STEPS];
    logic [SQ_STEPS-1:0]     sq_root_reg [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_side_reg[0] <= '0;
        end
        else if (en)
        begin
            sq_side_reg[0] <= sq_seed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // negative discriminant takes no root: feed zero
            sq_x_reg[0]    <= disc_next[DISC_W-1] ? '0
                              : {disc_next[SQ_IN_W-17:0], 16'b0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sqrt
            logic [SQ_REM_W-1:0] sh;
            logic [SQ_REM_W-1:0] trial;
            logic                ge;

            assign sh    = {sq_rem_reg[k][SQ_REM_W-3:0],
                            sq_x_reg[k][SQ_IN_W-1-2*k], sq_x_reg[k][SQ_IN_W-2-2*k]};
            assign trial = {2'b00, sq_root_reg[k], 2'b01};
            assign ge    = (sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_side_reg[k+1] <= '0;
                end
                else if (en)
                begin
                    sq_side_reg[k+1] <= sq_side_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_x_reg[k+1]    <= sq_x_reg[k];
                    sq_rem_reg[k+1]  <= ge ? (sh - trial) : sh;
                    sq_root_reg[k+1] <= {sq_root_reg[k][SQ_STEPS-2:0], ge};
                end
            end
        end
    endgenerate

    // ---------------- operand stage: numerators, denominators, signs ----------------
    sq_side_t                 sq_last;
    logic signed [NUM_W-1:0]  bq_ext, s_ext, n_rp, n_rm, n_vx, n_vy;
    logic        [COEF_W-1:0] abs_a;
    logic                     a_neg;
    div_side_t                op_side;

    assign sq_last = sq_side_reg[SQ_STEPS];
    assign a_neg   = sq_last.a[COEF_W-1];
    assign abs_a   = a_neg ? (~sq_last.a + COEF_W'(1)) : sq_last.a;
    assign bq_ext  = {{(NUM_W - BQ_W){sq_last.bq[BQ_W-1]}}, sq_last.bq};
    assign s_ext   = {{(NUM_W - SQ_STEPS){1'b0}}, sq_root_reg[SQ_STEPS]};
    assign n_rp    = s_ext - bq_ext;
    assign n_rm    = -s_ext - bq_ext;
    assign n_vx    = -bq_ext;
    assign n_vy    = -{{(NUM_W - DISC_W){sq_last.disc[DISC_W-1]}}, sq_last.disc};

    always_comb
    begin
        op_side.valid  = sq_last.valid;
        op_side.disc   = sq_last.disc;
        op_side.neg_rp = n_rp[NUM_W-1] ^ a_neg;
        op_side.neg_rm = n_rm[NUM_W-1] ^ a_neg;
        op_side.neg_vx = n_vx[NUM_W-1] ^ a_neg;
        op_side.neg_vy = n_vy[NUM_W-1] ^ a_neg;
        priority if (sq_last.a == '0)
            op_side.cls = CLS_DEGEN;
        else if (sq_last.disc[DISC_W-1])
            op_side.cls = CLS_COMPLEX;
        else if (sq_last.disc == '0)
            op_side.cls = CLS_DOUBLE;
        else
            op_side.cls = CLS_TWO;
    end

    div_side_t         dv_side_reg [0:DIV_NW];
    logic [DIV_NW-1:0] op_rp_reg, op_rm_reg, op_vx_reg, op_vy_reg;
    logic [DIV_DW-1:0] op_d2_reg, op_d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_side_reg[0] <= '0;
        end
        else if (en)
        begin
            dv_side_reg[0] <= op_side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_rp_reg <= {abs_mag(n_rp), 16'b0};
            op_rm_reg <= {abs_mag(n_rm), 16'b0};
            op_vx_reg <= {abs_mag(n_vx), 16'b0};
            op_vy_reg <= {abs_mag(n_vy), 16'b0};
            op_d2_reg <= {1'b0, abs_a, 9'b0};
            op_d4_reg <= {abs_a, 10'b0};
        end
    end

    // ---------------- dividers ----------------
    logic [DIV_NW-1:0] q_rp, q_rm, q_vx, q_vy;

    rqs_div u_div_rp (.clk(clk), .en(en), .num(op_rp_reg), .den(op_d2_reg), .quo(q_rp));
    rqs_div u_div_rm (.clk(clk), .en(en), .num(op_rm_reg), .den(op_d2_reg), .quo(q_rm));
    rqs_div u_div_vx (.clk(clk), .en(en), .num(op_vx_reg), .den(op_d2_reg), .quo(q_vx));
    rqs_div u_div_vy (.clk(clk), .en(en), .num(op_vy_reg), .den(op_d4_reg), .quo(q_vy));

    // carry class, discriminant and signs alongside the dividers
    genvar d;
    generate
        for (d = 0; d < DIV_NW; d++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_side_reg[d+1] <= '0;
                end
                else if (en)
                begin
                    dv_side_reg[d+1] <= dv_side_reg[d];
                end
            end
        end
    endgenerate

    // ---------------- output stage ----------------
    div_side_t dv_last;
    sat_t      sat_rp, sat_rm, sat_vx, sat_vy;
    logic      has_roots, degen;

    assign dv_last   = dv_side_reg[DIV_NW];
    assign sat_rp    = sat_q(q_rp, dv_last.neg_rp);
    assign sat_rm    = sat_q(q_rm, dv_last.neg_rm);
    assign sat_vx    = sat_q(q_vx, dv_last.neg_vx);
    assign sat_vy    = sat_q(q_vy, dv_last.neg_vy);
    assign degen     = (dv_last.cls == CLS_DEGEN);
    assign has_roots = (dv_last.cls == CLS_TWO) || (dv_last.cls == CLS_DOUBLE);

    logic                     out_valid_reg;
    root_class_t              out_cls_reg;
    logic signed [DISC_W-1:0] out_disc_reg;
    logic        [RES_W-1:0]  out_rp_reg, out_rm_reg, out_vx_reg, out_vy_reg;
    logic                     out_ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cls_reg  <= dv_last.cls;
            out_disc_reg <= degen ? '0 : dv_last.disc;
            out_rp_reg   <= has_roots ? sat_rp.value : '0;
            out_rm_reg   <= has_roots ? sat_rm.value : '0;
            out_vx_reg   <= degen ? '0 : sat_vx.value;
            out_vy_reg   <= degen ? '0 : sat_vy.value;
            out_ov_reg   <= !degen && ((has_roots && (sat_rp.ov || sat_rm.ov))
                                       || sat_vx.ov || sat_vy.ov);
        end
    end

    assign out_valid     = out_valid_reg;
    assign root_class    = out_cls_reg;
    assign disc_value    = out_disc_reg;
    assign root_plus     = out_rp_reg;
    assign root_minus    = out_rm_reg;
    assign vertex_x      = out_vx_reg;
    assign vertex_y      = out_vy_reg;
    assign overflow_flag = out_ov_reg;

endmodule

`default_nettype wire

>>> rtl/rqs_div.sv
`default_nettype none

module rqs_div
    import rqs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic      [DIV_NW-1:0] quo
);

    logic [DIV_NW-1:0] num_reg [1:DIV_NW];
    logic [DIV_DW-1:0] den_reg [1:DIV_NW];
    logic [DIV_DW-1:0] rem_reg [1:DIV_NW];
    logic [DIV_NW-1:0] quo_reg [1:DIV_NW];

    logic [DIV_NW-1:0] cur_num [0:DIV_NW-1];
    logic [DIV_DW-1:0] cur_den [0:DIV_NW-1];
    logic [DIV_DW-1:0] cur_rem [0:DIV_NW-1];
    logic [DIV_NW-1:0] cur_quo [0:DIV_NW-1];

    assign cur_num[0] = num;
    assign cur_den[0] = den;
    assign cur_rem[0] = '0;
    assign cur_quo[0] = '0;

    genvar i;
    generate
        for (i = 0; i < DIV_NW; i++)
        begin : g_stage
            logic [DIV_DW:0]   sh;
            logic              ge;
            logic [DIV_DW:0]   diff;
            logic [DIV_DW-1:0] rem_next;
            logic [DIV_NW-1:0] quo_next;

            if (i > 0)
            begin : g_link
                assign cur_num[i] = num_reg[i];
                assign cur_den[i] = den_reg[i];
                assign cur_rem[i] = rem_reg[i];
                assign cur_quo[i] = quo_reg[i];
            end

            // shift in one numerator bit, subtract when it fits
            assign sh       = {cur_rem[i], cur_num[i][DIV_NW-1-i]};
            assign ge       = (sh >= {1'b0, cur_den[i]});
            assign diff     = sh - {1'b0, cur_den[i]};
            assign rem_next = ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
            assign quo_next = {cur_quo[i][DIV_NW-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[i+1] <= cur_num[i];
                    den_reg[i+1] <= cur_den[i];
                    rem_reg[i+1] <= rem_next;
                    quo_reg[i+1] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_NW];

endmodule

`default_nettype wire

>>> rtl/rqs_check.sv
`default_nettype none

module rqs_check
    import rqs_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_stall,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic             [1:0]   root_class,
    input wire logic signed [DISC_W-1:0] disc_value,
    input wire logic signed [RES_W-1:0]  root_plus,
    input wire logic signed [RES_W-1:0]  root_minus,
    input wire logic signed [RES_W-1:0]  vertex_x,
    input wire logic signed [RES_W-1:0]  vertex_y,
    input wire logic                     overflow_flag
);

    // held word stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped under stall");

    // input is refused exactly while the output word is held
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output hold");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_class == CLS_DEGEN |->
            disc_value == '0 && root_plus == '0 && root_minus == '0 &&
            vertex_x == '0 && vertex_y == '0 && !overflow_flag)
        else $error("degenerate word carries nonzero fields");

    a_complex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_class == CLS_COMPLEX |->
            disc_value < 0 && root_plus == '0 && root_minus == '0)
        else $error("complex class with roots or nonnegative discriminant");

    a_double: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_class == CLS_DOUBLE |->
            disc_value == '0 && root_plus == root_minus)
        else $error("double root mismatch");

endmodule

bind quadratic_root_solver rqs_check u_rqs_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .root_class   (root_class),
    .disc_value   (disc_value),
    .root_plus    (root_plus),
    .root_minus   (root_minus),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .overflow_flag(overflow_flag)
);

`default_nettype wire

>>> tb/sv/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import rqs_pkg::*;

    // Fixed arithmetic of this build: Q8.8 coefficients, Q16.16 results.
    localparam int        CLK_HALF    = 5;
    localparam int        PIPE_LAT    = 80;
    localparam longint    CYCLE_LIMIT = 2000000;
    localparam longint    DISC_HI     = 64'sd17179869183;
    localparam longint    DISC_LO     = -64'sd17179869184;

    typedef struct {
        root_class_t    cls;
        logic [34:0]    disc;
        logic [31:0]    rp;
        logic [31:0]    rm;
        logic [31:0]    vx;
        logic [31:0]    vy;
        logic           ov;
    } roots_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               root_class;
    logic signed [DISC_W-1:0] disc_value;
    logic signed [RES_W-1:0]  root_plus;
    logic signed [RES_W-1:0]  root_minus;
    logic signed [RES_W-1:0]  vertex_x;
    logic signed [RES_W-1:0]  vertex_y;
    logic                     overflow_flag;

    roots_t expected_roots[$];
    int     mismatch_count;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;

    quadratic_root_solver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coef_a        (coef_a),
        .coef_b        (coef_b),
        .coef_c        (coef_c),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .root_class    (root_class),
        .disc_value    (disc_value),
        .root_plus     (root_plus),
        .root_minus    (root_minus),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .overflow_flag (overflow_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Floor square root, one result bit per pass.
    function automatic longint isqrt_down(input longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return longint'(r);
    endfunction

    // (n * 2^16) / d, truncated toward zero, clamped to int32; raise ov on clamp.
    function automatic longint q16_divide(input longint n, input longint d, inout logic ov);
        logic            neg;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned r;
        longint unsigned lim;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? longint'(-n) : n;
        ud  = (d < 0) ? longint'(-d) : d;
        q   = un / ud;
        r   = un % ud;
        lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        for (int i = 0; i < 16; i++)
        begin
            if (q > lim)
                break;
            q <<= 1;
            r <<= 1;
            if (r >= ud)
            begin
                r -= ud;
                q++;
            end
        end
        if (q > lim)
        begin
            ov = 1'b1;
            q  = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic roots_t solve_quadratic(input logic signed [15:0] a_in,
                                               input logic signed [15:0] b_in,
                                               input logic signed [15:0] c_in);
        roots_t res;
        longint a;
        longint b;
        longint c;
        longint dq;
        longint aq;
        longint bq;
        longint s;
        logic   ov;
        a   = a_in;
        b   = b_in;
        c   = c_in;
        ov  = 1'b0;
        res = '{CLS_DEGEN, '0, '0, '0, '0, '0, 1'b0};
        if (a == 0)
            return res;
        // Q16 product of Q8 terms: no shift needed at eight fraction bits.
        dq = b * b - 4 * a * c;
        if (dq > DISC_HI) begin dq = DISC_HI; ov = 1'b1; end
        if (dq < DISC_LO) begin dq = DISC_LO; ov = 1'b1; end
        aq = a * 256;
        bq = b * 256;
        if (dq >= 0)
        begin
            s       = isqrt_down(longint'(dq) << 16);
            res.cls = (dq > 0) ? CLS_TWO : CLS_DOUBLE;
            res.rp  = 32'(q16_divide(-bq + s, 2 * aq, ov));
            res.rm  = 32'(q16_divide(-bq - s, 2 * aq, ov));
        end
        else
            res.cls = CLS_COMPLEX;
        res.vx   = 32'(q16_divide(-bq, 2 * aq, ov));
        res.vy   = 32'(q16_divide(-dq, 4 * aq, ov));
        res.disc = 35'(dq);
        res.ov   = ov;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Send one coefficient word; hold it until the block takes it. Valid stays
    // up afterwards so the next word can follow at once.
    task automatic send_coefs(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic signed [15:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coef_a   <= a;
        coef_b   <= b;
        coef_c   <= c;
        expected_roots.push_back(solve_quadratic(a, b, c));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Receiver: randomize stall each edge, check each accepted result word.
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    want = expected_roots.pop_front();
                    if (root_class != want.cls)
                        report_mismatch("root_class", root_class, want.cls);
                    if (disc_value != want.disc)
                        report_mismatch("disc_value", disc_value, $signed(want.disc));
                    if (root_plus != want.rp)
                        report_mismatch("root_plus", root_plus, $signed(want.rp));
                    if (root_minus != want.rm)
                        report_mismatch("root_minus", root_minus, $signed(want.rm));
                    if (vertex_x != want.vx)
                        report_mismatch("vertex_x", vertex_x, $signed(want.vx));
                    if (vertex_y != want.vy)
                        report_mismatch("vertex_y", vertex_y, $signed(want.vy));
                    if (overflow_flag != want.ov)
                        report_mismatch("overflow_flag", overflow_flag, want.ov);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Extremes, zero a, double root, complex roots, saturation.
    task automatic test_directed();
        send_coefs(16'sd0, 16'sd0, 16'sd0);
        send_coefs(16'sd0, 16'sh7fff, -16'sd32768);
        send_coefs(16'sd256, 16'sd0, -16'sd256);
        send_coefs(16'sd256, -16'sd512, 16'sd256);
        send_coefs(16'sd256, 16'sd0, 16'sd256);
        send_coefs(16'sd1, 16'sh7fff, 16'sd0);
        send_coefs(-16'sd1, -16'sd32768, 16'sd0);
        send_coefs(16'sd1, 16'sd0, -16'sd32768);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
        send_coefs(-16'sd32768, 16'sd0, 16'sh7fff);
        send_coefs(16'sh7fff, -16'sd32768, -16'sd32768);
        send_coefs(-16'sd1, -16'sd1, -16'sd1);
        send_coefs(16'sd1, 16'sd2, 16'sd1);
        send_coefs(16'sd1, 16'sd1, 16'sd1);
        send_coefs(-16'sd256, 16'sd768, -16'sd512);
        send_coefs(16'sd3, -16'sd7, 16'sd5);
        send_coefs(16'sd1, 16'sd0, 16'sd0);
    endtask

    // Mix of full-range, small-magnitude and perfect-square cases.
    task automatic test_random(input int count);
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        for (int i = 0; i < count; i++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'($urandom);
            case ($urandom_range(3))
                0: begin a = 16'($signed($urandom_range(64)) - 32);
                         b = 16'($signed($urandom_range(2048)) - 1024); end
                1: c = 16'((b * b) / (4 * ((a == 0) ? 16'sd1 : a)));
                2: if ($urandom_range(9) == 0) a = 16'sd0;
                default: ;
            endcase
            send_coefs(a, b, c);
        end
    endtask

    // Drop valid after the last word, then wait for every result.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 20) @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        coef_a         = '0;
        coef_b         = '0;
        coef_c         = '0;
        out_stall      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        set_idling(0, 0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_idling(0, 0);
        test_random(250);
        set_idling(53, 0);
        test_random(250);
        set_idling(0, 53);
        test_random(250);
        set_idling(21, 21);
        test_random(250);
        drain();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
